// ===== hdl/rfb_pkg.sv =====
// Shared types, sizes and register offsets for the renderer FIFO and banked RAM port.
package rfb_pkg;

    localparam int FIFO_DEPTH = 2048;
    localparam int FIFO_AW    = $clog2(FIFO_DEPTH);
    localparam int FIFO_HALF  = FIFO_DEPTH / 2;

    localparam int BANK_WORDS = 4096;
    localparam int BANK_AW    = $clog2(BANK_WORDS);
    localparam int RAM_AW     = BANK_AW + 1;
    localparam int BANK_BIT   = 22;

    localparam logic [8:0]  OFS_FIFO_HI    = 9'h000;
    localparam logic [8:0]  OFS_FIFO_LO    = 9'h001;
    localparam logic [8:0]  OFS_STATUS     = 9'h11b;
    localparam logic [8:0]  OFS_SLV_STATUS = 9'h11c;
    localparam logic [8:0]  OFS_FIFO_CLR   = 9'h11d;
    localparam logic [8:0]  OFS_PTR_LOAD   = 9'h11e;
    localparam logic [8:0]  OFS_RAM_DATA   = 9'h11f;
    localparam logic [15:0] STATUS_VALUE   = 16'h8000;

    localparam logic FUNC_READ  = 1'b0;
    localparam logic FUNC_WRITE = 1'b1;

    typedef struct packed {
        logic        func;
        logic [8:0]  reg_offset;
        logic [31:0] write_data;
    } t_in;

    typedef struct packed {
        logic [15:0] read_data;
        logic        dsp_flag;
    } t_out;

    typedef struct packed {
        logic push;
        logic pop;
        logic rd;
        logic clear;
    } t_fifo_cmd;

    typedef struct packed {
        logic load;
        logic wr;
        logic rd;
    } t_ram_cmd;

    typedef enum logic [2:0] {
        RS_ZERO,
        RS_FIFO_HI,
        RS_FIFO_LO,
        RS_STATUS,
        RS_RAM
    } t_rsel;

endpackage

// ===== hdl/rfb_fifo.sv =====
// FIFO word store with read and write indices and the DSP flag.
module rfb_fifo (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  rfb_pkg::t_fifo_cmd i_cmd,
    input  logic [31:0]        i_wdata,
    output logic [31:0]        o_rdata,
    output logic               o_flag
);
    import rfb_pkg::*;

    logic [31:0]        r_mem [FIFO_DEPTH];
    logic [31:0]        r_rdata;
    logic [FIFO_AW-1:0] r_rd_idx;
    logic [FIFO_AW-1:0] r_wr_idx;
    logic               r_flag;
    logic [FIFO_AW-1:0] n_rd_idx;
    logic [FIFO_AW-1:0] n_wr_idx;

    always_comb begin
        n_rd_idx = (r_rd_idx == FIFO_AW'(FIFO_DEPTH - 1)) ? '0 : r_rd_idx + 1'b1;
        n_wr_idx = (r_wr_idx == FIFO_AW'(FIFO_DEPTH - 1)) ? '0 : r_wr_idx + 1'b1;
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.push) begin
            r_mem[r_wr_idx] <= i_wdata;
        end
        if (i_cmd.rd) begin
            r_rdata <= r_mem[r_rd_idx];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rd_idx <= '0;
            r_wr_idx <= '0;
            r_flag   <= 1'b0;
        end else begin
            priority if (i_cmd.clear) begin
                r_rd_idx <= '0;
                r_wr_idx <= '0;
            end else if (i_cmd.push) begin
                r_flag   <= (r_wr_idx < FIFO_AW'(FIFO_HALF));
                r_wr_idx <= n_wr_idx;
            end else if (i_cmd.pop) begin
                // drop the flag only while the read index is below half depth minus one
                r_flag   <= !(r_rd_idx < FIFO_AW'(FIFO_HALF - 1));
                r_rd_idx <= n_rd_idx;
            end
        end
    end

    assign o_rdata = r_rdata;
    assign o_flag  = r_flag;

endmodule

// ===== hdl/rfb_bank.sv =====
// Two-bank 16-bit RAM behind an auto-incrementing 32-bit pointer.
module rfb_bank (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  rfb_pkg::t_ram_cmd i_cmd,
    input  logic [31:0]       i_wdata,
    output logic [15:0]       o_rdata
);
    import rfb_pkg::*;

    logic [15:0]       r_mem [2 * BANK_WORDS];
    logic [15:0]       r_rdata;
    logic [31:0]       r_ptr;
    logic [RAM_AW-1:0] addr;

    // bank bit on top, word offset masked to the bank size below
    assign addr = {r_ptr[BANK_BIT], r_ptr[BANK_AW-1:0]};

    always_ff @(posedge i_clk) begin
        if (i_cmd.wr) begin
            r_mem[addr] <= i_wdata[15:0];
        end
        if (i_cmd.rd) begin
            r_rdata <= r_mem[addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ptr <= '0;
        end else if (i_cmd.load) begin
            r_ptr <= i_wdata;
        end else if (i_cmd.wr || i_cmd.rd) begin
            r_ptr <= r_ptr + 32'd1;
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== hdl/renderer_fifo_and_banked_ram_port_unit.sv =====
// Top level: access decode, memory read stage and output register.
//
//   channel | direction | handshake                 | payload
//   --------+-----------+---------------------------+-----------------------------
//   in      | input     | i_in_valid / o_in_ready   | i_in_data  (func, offset, data)
//   out     | output    | o_out_valid / i_out_ready | o_out_data (read_data, flag)
//
// One access per cycle while the output is not stalled; a taken access passes the read
// stage, then the output register. Each access issues at most one port operation on the
// FIFO store or the bank RAM; the synchronous read of that memory feeds the read stage.
// Reset is synchronous and active low; it clears indices, pointer, flag and valids,
// not memory contents.
// A stalled output holds the read stage, which holds the input side.
module renderer_fifo_and_banked_ram_port_unit (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_ready,
    input  rfb_pkg::t_in  i_in_data,
    output logic          o_out_valid,
    input  logic          i_out_ready,
    output rfb_pkg::t_out o_out_data
);
    import rfb_pkg::*;

    t_fifo_cmd   fifo_cmd;
    t_ram_cmd    ram_cmd;
    t_rsel       sel;
    logic        in_acc;
    logic        s1_move;
    logic [31:0] fifo_rdata;
    logic [15:0] ram_rdata;
    logic        flag;
    logic [15:0] rdata_mux;

    logic        r_s1_valid;
    t_rsel       r_s1_sel;
    logic        r_out_valid;
    t_out        r_out;

    assign s1_move    = r_s1_valid && (!r_out_valid || i_out_ready);
    assign o_in_ready = !r_s1_valid || s1_move;
    assign in_acc     = i_in_valid && o_in_ready;

    always_comb begin
        fifo_cmd = '0;
        ram_cmd  = '0;
        sel      = RS_ZERO;
        if (i_in_data.func == FUNC_WRITE) begin
            unique case (i_in_data.reg_offset)
                OFS_FIFO_HI:  fifo_cmd.push  = in_acc;
                OFS_FIFO_CLR: fifo_cmd.clear = in_acc;
                OFS_PTR_LOAD: ram_cmd.load   = in_acc;
                OFS_RAM_DATA: ram_cmd.wr     = in_acc;
                default: ;
            endcase
        end else begin
            unique case (i_in_data.reg_offset)
                OFS_FIFO_HI: begin
                    fifo_cmd.rd = in_acc;
                    sel         = RS_FIFO_HI;
                end
                OFS_FIFO_LO: begin
                    fifo_cmd.rd  = in_acc;
                    fifo_cmd.pop = in_acc;
                    sel          = RS_FIFO_LO;
                end
                OFS_STATUS, OFS_SLV_STATUS: sel = RS_STATUS;
                OFS_RAM_DATA: begin
                    ram_cmd.rd = in_acc;
                    sel        = RS_RAM;
                end
                default: ;
            endcase
        end
    end

    rfb_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (fifo_cmd),
        .i_wdata (i_in_data.write_data),
        .o_rdata (fifo_rdata),
        .o_flag  (flag)
    );

    rfb_bank u_bank (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (ram_cmd),
        .i_wdata (i_in_data.write_data),
        .o_rdata (ram_rdata)
    );

    always_comb begin
        unique case (r_s1_sel)
            RS_FIFO_HI: rdata_mux = fifo_rdata[31:16];
            RS_FIFO_LO: rdata_mux = fifo_rdata[15:0];
            RS_STATUS:  rdata_mux = STATUS_VALUE;
            RS_RAM:     rdata_mux = ram_rdata;
            default:    rdata_mux = '0;
        endcase
    end

    // Memory read data stays put until the next access, so the read stage may hold.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (in_acc) begin
                r_s1_valid <= 1'b1;
            end else if (s1_move) begin
                r_s1_valid <= 1'b0;
            end
            if (s1_move) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_s1_sel <= sel;
        end
        if (s1_move) begin
            // flag register still reflects this transaction at the move edge
            r_out.read_data <= rdata_mux;
            r_out.dsp_flag  <= flag;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    a_acc_fills_s1: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc |=> r_s1_valid)
        else $error("accepted transaction did not reach the read stage");

    a_s1_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s1_valid && !s1_move) |=> (r_s1_valid && $stable(r_s1_sel)))
        else $error("stalled read stage lost its transaction");

    a_status_value: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s1_move && (r_s1_sel == RS_STATUS)) |=> (o_out_data.read_data == STATUS_VALUE))
        else $error("status read returned a wrong value");

    a_ready_when_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_s1_valid |-> o_in_ready)
        else $error("input stalled with an empty read stage");

endmodule
